### hdl/cft_pkg.sv
// Package for the CSV field tokenizer: action codes, queue entry layout,
// register indexes and reset values. No dependencies.
`default_nettype none

package cft_pkg;

    localparam int SPACE_DEPTH_DEFAULT = 16;
    localparam int QUEUE_DEPTH         = 4;
    localparam int CFG_INDEX_W         = 3;
    localparam int BYTE_W              = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DELIMITER  = 3'd0,
        REG_QUOTE      = 3'd1,
        REG_ESCAPE     = 3'd2,
        REG_TRIM       = 3'd3,
        REG_STRICT     = 3'd4,
        REG_SKIP_EMPTY = 3'd5
    } reg_index_t;

    localparam logic [BYTE_W-1:0] DELIMITER_RESET = 8'd44;
    localparam logic [BYTE_W-1:0] QUOTE_RESET     = 8'd34;
    localparam logic [BYTE_W-1:0] ESCAPE_RESET    = 8'd92;
    localparam logic              TRIM_RESET      = 1'b1;
    localparam logic              STRICT_RESET    = 1'b0;
    localparam logic              SKIP_RESET      = 1'b1;

    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_BLANK,
        ACT_BYTE,
        ACT_END
    } act_kind_t;

    typedef struct packed {
        act_kind_t         kind;
        logic [BYTE_W-1:0] data;
        logic              line;
        logic              last;
    } act_t;

    typedef struct packed {
        act_t a1;
        act_t a0;
    } entry_t;

endpackage

`default_nettype wire

### hdl/cft_front.sv
// Front part of the CSV field tokenizer: configuration registers, quoting and
// lookahead state, and classification of each input transfer into actions.
// Depends on cft_pkg.
`default_nettype none

module cft_front #(
    parameter int SPACE_DEPTH = cft_pkg::SPACE_DEPTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [cft_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [cft_pkg::BYTE_W-1:0]    cfg_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [cft_pkg::BYTE_W-1:0]    s_tdata,
    input  wire logic                          s_tlast,
    output logic                               push,
    output cft_pkg::entry_t                    push_entry,
    input  wire logic                          queue_full
);
    import cft_pkg::*;

    localparam int CW = $clog2(SPACE_DEPTH + 1);

    typedef struct packed {
        logic          quoted;
        logic          started;
        logic [CW-1:0] cnt;
    } trk_t;

    typedef struct packed {
        trk_t st;
        act_t act;
        logic emits;
    } step_t;

    localparam act_t ACT_IDLE = '{ACT_NONE, 8'd0, 1'b0, 1'b0};

    logic [BYTE_W-1:0] delim_reg, quote_reg, escape_reg;
    logic              trim_reg, strict_reg, skip_reg;

    logic          quoted_reg, quoted_next;
    logic          held_reg, held_next;
    logic          held_esc_reg, held_esc_next;
    logic          started_reg, started_next;
    logic          line_bytes_reg, line_bytes_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          accept;
    act_t          act0, act1;

    function automatic logic is_blank(input logic [BYTE_W-1:0] b);
        return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_CR) || (b == CHAR_LF);
    endfunction

    function automatic step_t do_end(input trk_t st, input logic line);
        step_t r;
        r.st         = st;
        r.st.cnt     = '0;
        r.st.started = 1'b0;
        r.act        = '{ACT_END, 8'd0, line, 1'b0};
        r.emits      = 1'b1;
        return r;
    endfunction

    function automatic step_t do_append(input trk_t st, input logic [BYTE_W-1:0] b,
                                        input logic trim);
        step_t r;
        r.st    = st;
        r.act   = ACT_IDLE;
        r.emits = 1'b0;
        if (trim && is_blank(b))
        begin
            if (st.started)
            begin
                r.act.kind = ACT_BLANK;
                r.act.data = b;
                if (st.cnt < CW'(SPACE_DEPTH))
                begin
                    r.st.cnt = st.cnt + CW'(1);
                end
                else
                begin
                    r.emits = 1'b1;
                end
            end
        end
        else
        begin
            r.st.cnt     = '0;
            r.st.started = 1'b1;
            r.act.kind   = ACT_BYTE;
            r.act.data   = b;
            r.emits      = 1'b1;
        end
        return r;
    endfunction

    function automatic step_t do_plain(input trk_t st, input logic [BYTE_W-1:0] b,
                                       input logic [BYTE_W-1:0] quote,
                                       input logic [BYTE_W-1:0] delim, input logic trim);
        step_t r;
        r.st    = st;
        r.act   = ACT_IDLE;
        r.emits = 1'b0;
        if (b == quote)
        begin
            r.st.quoted = ~st.quoted;
        end
        else if ((b == delim) && !st.quoted)
        begin
            r = do_end(st, 1'b0);
        end
        else
        begin
            r = do_append(st, b, trim);
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg  <= DELIMITER_RESET;
            quote_reg  <= QUOTE_RESET;
            escape_reg <= ESCAPE_RESET;
            trim_reg   <= TRIM_RESET;
            strict_reg <= STRICT_RESET;
            skip_reg   <= SKIP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DELIMITER:  delim_reg  <= cfg_data;
                REG_QUOTE:      quote_reg  <= cfg_data;
                REG_ESCAPE:     escape_reg <= cfg_data;
                REG_TRIM:       trim_reg   <= cfg_data[0];
                REG_STRICT:     strict_reg <= cfg_data[0];
                REG_SKIP_EMPTY: skip_reg   <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin : classify
        trk_t              st;
        step_t             s0, s1;
        logic              consumed;
        logic [BYTE_W-1:0] c;
        st.quoted     = quoted_reg;
        st.started    = started_reg;
        st.cnt        = cnt_reg;
        s0            = '{st, ACT_IDLE, 1'b0};
        s1            = '{st, ACT_IDLE, 1'b0};
        consumed      = 1'b0;
        c             = s_tdata;
        held_next     = held_reg;
        held_esc_next = held_esc_reg;
        line_bytes_next = line_bytes_reg;

        if (s_tlast)
        begin
            if (held_reg)
            begin
                if (held_esc_reg)
                begin
                    s0 = do_plain(st, escape_reg, quote_reg, delim_reg, trim_reg);
                end
                else
                begin
                    s0.st.quoted = ~st.quoted;
                end
            end
            s1.st = s0.st;
            if (!(skip_reg && !line_bytes_reg))
            begin
                s1 = do_end(s0.st, 1'b1);
            end
            s1.st           = '{1'b0, 1'b0, '0};
            held_next       = 1'b0;
            held_esc_next   = 1'b0;
            line_bytes_next = 1'b0;
        end
        else
        begin
            line_bytes_next = 1'b1;
            if (held_reg)
            begin
                held_next = 1'b0;
                if (c == quote_reg)
                begin
                    s0       = do_append(st, quote_reg, trim_reg);
                    consumed = 1'b1;
                end
                else if (held_esc_reg)
                begin
                    s0 = do_plain(st, escape_reg, quote_reg, delim_reg, trim_reg);
                end
                else
                begin
                    s0.st.quoted = ~st.quoted;
                end
            end
            s1.st = s0.st;
            if (!consumed)
            begin
                if (c == escape_reg)
                begin
                    held_next     = 1'b1;
                    held_esc_next = 1'b1;
                end
                else if (c == quote_reg)
                begin
                    if (!strict_reg && s0.st.quoted)
                    begin
                        held_next     = 1'b1;
                        held_esc_next = 1'b0;
                    end
                    else
                    begin
                        s1.st.quoted = ~s0.st.quoted;
                    end
                end
                else if ((c == delim_reg) && !s0.st.quoted)
                begin
                    s1 = do_end(s0.st, 1'b0);
                end
                else
                begin
                    s1 = do_append(s0.st, c, trim_reg);
                end
            end
        end

        s0.act.last = s0.emits && !s1.emits;
        s1.act.last = s1.emits;
        if (s0.act.kind == ACT_NONE)
        begin
            act0 = s1.act;
            act1 = ACT_IDLE;
        end
        else
        begin
            act0 = s0.act;
            act1 = s1.act;
        end

        quoted_next  = s1.st.quoted;
        started_next = s1.st.started;
        cnt_next     = s1.st.cnt;
    end

    assign s_tready      = !queue_full;
    assign accept        = s_tvalid && s_tready;
    assign push          = accept && (act0.kind != ACT_NONE);
    assign push_entry.a0 = act0;
    assign push_entry.a1 = act1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quoted_reg     <= 1'b0;
            held_reg       <= 1'b0;
            held_esc_reg   <= 1'b0;
            started_reg    <= 1'b0;
            line_bytes_reg <= 1'b0;
            cnt_reg        <= '0;
        end
        else if (accept)
        begin
            quoted_reg     <= quoted_next;
            held_reg       <= held_next;
            held_esc_reg   <= held_esc_next;
            started_reg    <= started_next;
            line_bytes_reg <= line_bytes_next;
            cnt_reg        <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### hdl/cft_queue.sv
// Short queue of classified entries between the front and back parts of the
// CSV field tokenizer. Depends on cft_pkg.
`default_nettype none

module cft_queue (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire cft_pkg::entry_t push_entry,
    output logic           full,
    input  wire logic      pop,
    output cft_pkg::entry_t head,
    output logic           head_valid
);
    import cft_pkg::*;

    localparam int LW = $clog2(QUEUE_DEPTH);

    entry_t        slot_reg [QUEUE_DEPTH];
    logic [LW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [LW:0]   fill_reg;
    logic          do_pop;

    assign full       = (fill_reg == (LW + 1)'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + LW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + LW'(1);
            end
            if (push && !do_pop)
            begin
                fill_reg <= fill_reg + (LW + 1)'(1);
            end
            else if (do_pop && !push)
            begin
                fill_reg <= fill_reg - (LW + 1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

### hdl/cft_back.sv
// Back part of the CSV field tokenizer: trailing-blank ring buffer, action
// sequencer, read stage and output register. Depends on cft_pkg.
`default_nettype none

module cft_back #(
    parameter int SPACE_DEPTH = cft_pkg::SPACE_DEPTH_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire cft_pkg::entry_t            head,
    input  wire logic                       head_valid,
    output logic                            pop,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [cft_pkg::BYTE_W-1:0]      m_tdata,
    output logic [1:0]                      m_tuser,
    output logic                            m_tlast
);
    import cft_pkg::*;

    localparam int CW = $clog2(SPACE_DEPTH + 1);
    localparam int AW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;

    logic [BYTE_W-1:0] space_buf_reg [SPACE_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    logic          phase_reg, phase_next;
    logic [AW-1:0] head_reg, head_next, head_inc, tail;
    logic [CW-1:0] count_reg, count_next;
    logic [AW:0]   tail_sum;

    logic              s1_valid_reg, s1_mem_reg, s1_fd_reg, s1_ld_reg, s1_last_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              out_valid_reg, out_fd_reg, out_ld_reg, out_last_reg;
    logic [BYTE_W-1:0] out_byte_reg;

    logic              s1_go, can_issue, issue, iss_mem, iss_fd, iss_ld, iss_last;
    logic [BYTE_W-1:0] iss_byte;
    logic              wr_en, done;
    logic [AW-1:0]     wr_addr;
    act_t              cur;

    assign tail_sum = (AW + 1)'(head_reg) + (AW + 1)'(count_reg);
    assign tail     = (tail_sum >= (AW + 1)'(SPACE_DEPTH)) ?
                      AW'(tail_sum - (AW + 1)'(SPACE_DEPTH)) : AW'(tail_sum);
    assign head_inc = (head_reg == AW'(SPACE_DEPTH - 1)) ? '0 : head_reg + AW'(1);

    assign s1_go     = !out_valid_reg || m_tready;
    assign can_issue = !s1_valid_reg || s1_go;
    assign cur       = phase_reg ? head.a1 : head.a0;

    always_comb
    begin
        issue      = 1'b0;
        iss_mem    = 1'b0;
        iss_byte   = cur.data;
        iss_fd     = 1'b0;
        iss_ld     = 1'b0;
        iss_last   = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = tail;
        done       = 1'b0;
        head_next  = head_reg;
        count_next = count_reg;
        phase_next = phase_reg;
        pop        = 1'b0;

        if (head_valid)
        begin
            case (cur.kind)
                ACT_BLANK:
                begin
                    if (count_reg < CW'(SPACE_DEPTH))
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                        done       = 1'b1;
                    end
                    else if (can_issue)
                    begin
                        issue     = 1'b1;
                        iss_mem   = 1'b1;
                        iss_last  = cur.last;
                        wr_en     = 1'b1;
                        wr_addr   = head_reg;
                        head_next = head_inc;
                        done      = 1'b1;
                    end
                end
                ACT_BYTE:
                begin
                    if (can_issue)
                    begin
                        issue = 1'b1;
                        if (count_reg != '0)
                        begin
                            iss_mem    = 1'b1;
                            head_next  = head_inc;
                            count_next = count_reg - CW'(1);
                        end
                        else
                        begin
                            iss_last = cur.last;
                            done     = 1'b1;
                        end
                    end
                end
                ACT_END:
                begin
                    if (can_issue)
                    begin
                        issue      = 1'b1;
                        iss_byte   = '0;
                        iss_fd     = 1'b1;
                        iss_ld     = cur.line;
                        iss_last   = cur.last;
                        count_next = '0;
                        done       = 1'b1;
                    end
                end
                default:
                begin
                    done = 1'b1;
                end
            endcase

            if (done)
            begin
                if (!phase_reg && (head.a1.kind != ACT_NONE))
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    phase_next = 1'b0;
                    pop        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            space_buf_reg[wr_addr] <= cur.data;
        end
        if (issue && iss_mem)
        begin
            rd_data_reg <= space_buf_reg[head_reg];
        end
        if (issue)
        begin
            s1_mem_reg  <= iss_mem;
            s1_byte_reg <= iss_byte;
            s1_fd_reg   <= iss_fd;
            s1_ld_reg   <= iss_ld;
            s1_last_reg <= iss_last;
        end
        if (s1_go && s1_valid_reg)
        begin
            out_byte_reg <= s1_mem_reg ? rd_data_reg : s1_byte_reg;
            out_fd_reg   <= s1_fd_reg;
            out_ld_reg   <= s1_ld_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            head_reg      <= '0;
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            if (issue)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_ld_reg, out_fd_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

### hdl/csv_field_tokenizer.sv
// Top level of the CSV field tokenizer: front classifier, entry queue and
// back sequencer. Depends on cft_pkg, cft_front, cft_queue and cft_back.
//
// The slave stream carries one character per transfer in s_tdata, or with
// s_tlast high an end-of-line item whose data is ignored. The master stream
// gives field content bytes in m_tdata; m_tuser[0] marks a field end and
// m_tuser[1] with it the last field of a line; m_tlast flags the final result
// caused by one input transfer. Registers are written through cfg_we,
// cfg_index and cfg_data; the user must do so only while the block is idle,
// which the block itself does not enforce. The front takes one transfer per
// cycle while the four-entry queue has room. The back gives the results of
// each action in order; an item that flushes buffered blanks before a byte
// gives each blank, then the byte. The first result of a transfer passes
// through the queue, the read stage and the output register before it shows
// on m_tvalid. When the receiver stalls, the output register and read stage
// hold and the queue fills, after which s_tready falls. Reset restores the
// register defaults and empties all state; the blank buffer needs no clearing.
`default_nettype none

module csv_field_tokenizer #(
    parameter int SPACE_DEPTH = cft_pkg::SPACE_DEPTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [cft_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [cft_pkg::BYTE_W-1:0]    cfg_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [cft_pkg::BYTE_W-1:0]    s_tdata,   // in_byte
    input  wire logic                          s_tlast,   // end_of_line
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [cft_pkg::BYTE_W-1:0]         m_tdata,   // out_byte
    output logic [1:0]                         m_tuser,   // field_done, line_done
    output logic                               m_tlast    // last
);
    import cft_pkg::*;

    logic   push, queue_full, pop, head_valid;
    entry_t push_entry, head;

    cft_front #(
        .SPACE_DEPTH(SPACE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push       (push),
        .push_entry (push_entry),
        .queue_full (queue_full)
    );

    cft_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    cft_back #(
        .SPACE_DEPTH(SPACE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

### sim/csv_field_tokenizer_tb.sv
// Self-checking testbench for csv_field_tokenizer: directed lines, then random CSV
// lines under several register settings, checked against a built-in tokenizer model.
// Depends on cft_pkg and csv_field_tokenizer.

module csv_field_tokenizer_tb;

    import cft_pkg::*;

    localparam int BLANK_DEPTH = SPACE_DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              eol;
    } line_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              field_end;
        logic              line_end;
        logic              final_one;
    } token_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]      cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [BYTE_W-1:0]      m_tdata;
    logic [1:0]             m_tuser;
    logic                   m_tlast;

    line_item_t pending_items[$];
    token_t     expected_tokens[$];
    int         error_count = 0;
    int         cycle_count = 0;
    int         queued_count;
    int         burst_left = 0;
    int         gap_left = 0;
    line_item_t next_item;
    token_t     want;

    // Tokenizer model: configuration copy and line state.
    logic [BYTE_W-1:0] cfg_delim, cfg_quote, cfg_esc;
    logic              cfg_trim, cfg_strict, cfg_skip;
    logic              quote_open, held_v, held_esc, fstarted, line_bytes;
    logic [BYTE_W-1:0] blank_buf [0:BLANK_DEPTH-1];
    int                blank_count;

    csv_field_tokenizer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #1 clk = ~clk;

    function automatic bit is_blank(logic [BYTE_W-1:0] b);
        return b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_CR || b == CHAR_LF;
    endfunction

    function void push_token(logic [BYTE_W-1:0] b, logic fe, logic le);
        token_t tok;
        tok.data      = b;
        tok.field_end = fe;
        tok.line_end  = le;
        tok.final_one = 1'b0;
        expected_tokens.insert(expected_tokens.size(), tok);
    endfunction

    function void flush_blanks();
        int i;
        for (i = 0; i < blank_count; i++)
            push_token(blank_buf[i], 1'b0, 1'b0);
        blank_count = 0;
    endfunction

    function void take_content(logic [BYTE_W-1:0] b);
        int i;
        if (cfg_trim && is_blank(b)) begin
            if (fstarted) begin
                if (blank_count < BLANK_DEPTH) begin
                    blank_buf[blank_count] = b;
                    blank_count = blank_count + 1;
                end else begin
                    push_token(blank_buf[0], 1'b0, 1'b0);
                    for (i = 0; i < BLANK_DEPTH - 1; i++)
                        blank_buf[i] = blank_buf[i+1];
                    blank_buf[BLANK_DEPTH-1] = b;
                end
            end
        end else begin
            flush_blanks();
            push_token(b, 1'b0, 1'b0);
            fstarted = 1'b1;
        end
    endfunction

    function void close_field(logic le);
        blank_count = 0;
        fstarted = 1'b0;
        push_token('0, 1'b1, le);
    endfunction

    function void plain_char(logic [BYTE_W-1:0] b);
        if (b == cfg_quote)
            quote_open = ~quote_open;
        else if (b == cfg_delim && !quote_open)
            close_field(1'b0);
        else
            take_content(b);
    endfunction

    function void new_char(logic [BYTE_W-1:0] c);
        if (c == cfg_esc) begin
            held_v = 1'b1;
            held_esc = 1'b1;
        end else if (c == cfg_quote) begin
            if (!cfg_strict && quote_open) begin
                held_v = 1'b1;
                held_esc = 1'b0;
            end else begin
                quote_open = ~quote_open;
            end
        end else if (c == cfg_delim && !quote_open) begin
            close_field(1'b0);
        end else begin
            take_content(c);
        end
    endfunction

    function void tokenize_item(logic [BYTE_W-1:0] c, logic eol);
        int     before_n;
        bit     taken;
        before_n = expected_tokens.size();
        taken = 1'b0;
        if (eol) begin
            if (held_v) begin
                held_v = 1'b0;
                if (held_esc)
                    plain_char(cfg_esc);
                else
                    quote_open = ~quote_open;
            end
            if (!(cfg_skip && !line_bytes))
                close_field(1'b1);
            quote_open = 1'b0;
            held_v = 1'b0;
            held_esc = 1'b0;
            fstarted = 1'b0;
            line_bytes = 1'b0;
            blank_count = 0;
        end else begin
            line_bytes = 1'b1;
            if (held_v) begin
                held_v = 1'b0;
                if (c == cfg_quote) begin
                    take_content(cfg_quote);
                    taken = 1'b1;
                end else if (held_esc) begin
                    plain_char(cfg_esc);
                end else begin
                    quote_open = ~quote_open;
                end
            end
            if (!taken)
                new_char(c);
        end
        if (expected_tokens.size() > before_n)
            expected_tokens[expected_tokens.size() - 1].final_one = 1'b1;
    endfunction

    function void add_item(logic [BYTE_W-1:0] c, logic eol);
        line_item_t it;
        it.ch  = c;
        it.eol = eol;
        pending_items.insert(pending_items.size(), it);
        queued_count = queued_count + 1;
    endfunction

    function automatic logic [BYTE_W-1:0] blank_char();
        case ($urandom_range(0, 3))
            0: return CHAR_SPACE;
            1: return CHAR_TAB;
            2: return CHAR_CR;
            default: return CHAR_LF;
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] content_char();
        logic [BYTE_W-1:0] c;
        if ($urandom_range(0, 3) == 0)
            return blank_char();
        c = BYTE_W'($urandom_range(0, 255));
        while (c == cfg_delim || c == cfg_quote || c == cfg_esc)
            c = BYTE_W'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic add_line();
        int nfields, flen, kind, f, i;
        nfields = $urandom_range(0, 4);
        for (f = 0; f < nfields; f++) begin
            if (f != 0)
                add_item(cfg_delim, 1'b0);
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                flen = $urandom_range(0, 6);
                for (i = 0; i < flen; i++)
                    add_item(content_char(), 1'b0);
            end else if (kind < 7) begin
                if ($urandom_range(0, 2) == 0)
                    add_item(blank_char(), 1'b0);
                add_item(cfg_quote, 1'b0);
                flen = $urandom_range(0, 5);
                for (i = 0; i < flen; i++) begin
                    case ($urandom_range(0, 5))
                        0: begin
                            add_item(cfg_quote, 1'b0);
                            add_item(cfg_quote, 1'b0);
                        end
                        1: begin
                            add_item(cfg_esc, 1'b0);
                            add_item(cfg_quote, 1'b0);
                        end
                        2: add_item(cfg_delim, 1'b0);
                        3: begin
                            add_item(cfg_esc, 1'b0);
                            add_item(content_char(), 1'b0);
                        end
                        default: add_item(content_char(), 1'b0);
                    endcase
                end
                add_item(cfg_quote, 1'b0);
                if ($urandom_range(0, 2) == 0)
                    add_item(blank_char(), 1'b0);
            end else if (kind == 7) begin
                add_item(BYTE_W'(8'h41 + $urandom_range(0, 25)), 1'b0);
                flen = $urandom_range(BLANK_DEPTH - 2, BLANK_DEPTH + 4);
                for (i = 0; i < flen; i++)
                    add_item(blank_char(), 1'b0);
                add_item(BYTE_W'(8'h61 + $urandom_range(0, 25)), 1'b0);
                flen = $urandom_range(0, BLANK_DEPTH + 2);
                for (i = 0; i < flen; i++)
                    add_item(blank_char(), 1'b0);
            end else begin
                flen = $urandom_range(1, 6);
                for (i = 0; i < flen; i++)
                    add_item(BYTE_W'($urandom_range(0, 255)), 1'b0);
            end
        end
        add_item(BYTE_W'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || s_tvalid || expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [BYTE_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_DELIMITER:  cfg_delim  = val;
            REG_QUOTE:      cfg_quote  = val;
            REG_ESCAPE:     cfg_esc    = val;
            REG_TRIM:       cfg_trim   = val[0];
            REG_STRICT:     cfg_strict = val[0];
            REG_SKIP_EMPTY: cfg_skip   = val[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(logic [BYTE_W-1:0] delim, logic [BYTE_W-1:0] quote,
                                logic [BYTE_W-1:0] esc, logic trim, logic strict,
                                logic skip);
        write_reg(REG_DELIMITER, delim);
        write_reg(REG_QUOTE, quote);
        write_reg(REG_ESCAPE, esc);
        write_reg(REG_TRIM, {7'd0, trim});
        write_reg(REG_STRICT, {7'd0, strict});
        write_reg(REG_SKIP_EMPTY, {7'd0, skip});
        queued_count = 0;
        while (queued_count < 10)
            add_line();
        wait_idle();
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                tokenize_item(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0 || pending_items.size() == 0) begin
                    s_tvalid <= 1'b0;
                    if (gap_left != 0)
                        gap_left = gap_left - 1;
                end else begin
                    next_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_item.ch;
                    s_tlast  <= next_item.eol;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left = burst_left - 1;
                    end
                end
            end
        end
    end

    task automatic check_field(string what, int wanted, int got);
        if (wanted != got) begin
            $display("%0t: %s expected %0h, actual %0h", $time, what, wanted, got);
            error_count = error_count + 1;
        end
    endtask

    // Receiver: checks each transfer and stalls on one of four patterns in turn.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_tokens.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual data %0h user %b last %b",
                             $time, m_tdata, m_tuser, m_tlast);
                    error_count = error_count + 1;
                end else begin
                    want = expected_tokens.pop_front();
                    check_field("out_byte", int'(want.data), int'(m_tdata));
                    check_field("field_done", int'(want.field_end), int'(m_tuser[0]));
                    check_field("line_done", int'(want.line_end), int'(m_tuser[1]));
                    check_field("last", int'(want.final_one), int'(m_tlast));
                end
            end
            case ((cycle_count / 97) % 4)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 2) != 0);
                2: m_tready <= ((cycle_count % 7) < 3);
                default: m_tready <= ((cycle_count % 16) >= 10);
            endcase
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("csv_field_tokenizer_tb NOT OK");
            $finish;
        end
    end

    initial begin
        cfg_delim   = DELIMITER_RESET;
        cfg_quote   = QUOTE_RESET;
        cfg_esc     = ESCAPE_RESET;
        cfg_trim    = TRIM_RESET;
        cfg_strict  = STRICT_RESET;
        cfg_skip    = SKIP_RESET;
        quote_open  = 1'b0;
        held_v      = 1'b0;
        held_esc    = 1'b0;
        fstarted    = 1'b0;
        line_bytes  = 1'b0;
        blank_count = 0;
        queued_count = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed lines under the reset settings.
        add_item(8'h00, 1'b1);
        add_item(CHAR_SPACE, 1'b0);
        add_item("a", 1'b0);
        add_item(",", 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(8'hFF, 1'b1);
        add_item("\"", 1'b0);
        add_item("x", 1'b0);
        add_item("\"", 1'b0);
        add_item("\"", 1'b0);
        add_item("\"", 1'b0);
        add_item(8'h00, 1'b1);
        add_item("\\", 1'b0);
        add_item("\"", 1'b0);
        add_item("\\", 1'b0);
        add_item(8'h00, 1'b0);
        add_item(8'h55, 1'b1);
        add_item("\\", 1'b0);
        add_item(8'hAA, 1'b1);
        add_item("\"", 1'b0);
        add_item("a", 1'b0);
        add_item("\"", 1'b0);
        add_item(8'h00, 1'b1);
        add_item("a", 1'b0);
        add_item(CHAR_SPACE, 1'b0);
        add_item(CHAR_TAB, 1'b0);
        wait_idle();
        // Trimming switched off with blanks still buffered in the open field.
        write_reg(REG_TRIM, 8'd0);
        add_item("b", 1'b0);
        add_item(8'h00, 1'b1);
        wait_idle();

        random_phase(8'h3B, 8'h27, 8'h5C, 1'b0, 1'b1, 1'b0);
        random_phase(8'h00, 8'hFF, 8'h00, 1'b1, 1'b0, 1'b0);
        random_phase(8'hFF, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1);
        random_phase(DELIMITER_RESET, QUOTE_RESET, ESCAPE_RESET, 1'b1, 1'b1, 1'b1);
        random_phase(DELIMITER_RESET, QUOTE_RESET, ESCAPE_RESET, 1'b1, 1'b0, 1'b0);

        if (error_count == 0)
            $display("csv_field_tokenizer_tb OK");
        else
            $display("csv_field_tokenizer_tb NOT OK");
        $finish;
    end

endmodule

### csv_field_tokenizer.f
hdl/cft_pkg.sv
hdl/cft_front.sv
hdl/cft_queue.sv
hdl/cft_back.sv
hdl/csv_field_tokenizer.sv
sim/csv_field_tokenizer_tb.sv
